FILE: rtl/core/ovx_pkg.sv
// Shared types, codes and trig helpers for the overlay vertex expander.
`default_nettype none

package ovx_pkg;

  // primitive kinds carried on the input tuser
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_CROSS  = 2'd1;
  localparam logic [1:0] KIND_RECT   = 2'd2;
  localparam logic [1:0] KIND_OVAL   = 2'd3;

  // entries in the command queue between front and back
  localparam int OVX_QDEPTH = 2;

  // Taylor coefficients of the quarter sine, unsigned Q30
  localparam logic [63:0] OVX_C1 = 64'd1686629713;
  localparam logic [63:0] OVX_C3 = 64'd693598668;
  localparam logic [63:0] OVX_C5 = 64'd85569306;
  localparam logic [63:0] OVX_C7 = 64'd5026990;
  localparam logic [63:0] OVX_C9 = 64'd172272;

  // quarter turn in phase units
  localparam logic [14:0] OVX_QUARTER = 15'd16384;

  typedef struct packed {
    logic [1:0] kind;
    logic       bend;
  } ovx_ctl_t;

  // sin(pi/2 * r/16384) in Q14; elaboration-time use only
  function automatic logic [15:0] ovx_qsine(input logic [14:0] r);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    z  = {33'd0, r, 16'd0};
    z2 = (z * z) >> 30;
    t  = OVX_C9;
    t  = OVX_C7 - ((z2 * t) >> 30);
    t  = OVX_C5 - ((z2 * t) >> 30);
    t  = OVX_C3 - ((z2 * t) >> 30);
    t  = OVX_C1 - ((z2 * t) >> 30);
    return 16'((((z * t) >> 30) + 64'd32768) >> 16);
  endfunction

  // cos (is_sin = 0) or sin (is_sin = 1) of a 16-bit phase, Q14 signed
  function automatic logic signed [15:0] ovx_trig(input logic [16:0] p, input logic is_sin);
    logic [14:0]        r;
    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] cv;
    logic signed [15:0] sv;
    r  = {1'b0, p[13:0]};
    sr = signed'(ovx_qsine(r));
    cr = signed'(ovx_qsine(OVX_QUARTER - r));
    case (p[15:14])
      2'd0: begin
        cv = cr;
        sv = sr;
      end
      2'd1: begin
        cv = -sr;
        sv = cr;
      end
      2'd2: begin
        cv = -cr;
        sv = -sr;
      end
      default: begin
        cv = sr;
        sv = -cr;
      end
    endcase
    return is_sin ? sv : cv;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/overlay_primitive_vertex_expander.sv
// Top level of the overlay primitive vertex expander.
//
//  channel | direction | tdata                          | tuser                    | tlast
//  in_     | slave     | coord_a, coord_b, coord_c,     | req_type                 | batch_end
//          |           | coord_d (low to high)          |                          |
//  out_    | master    | vertex_x, vertex_y             | overflow, batch_done     | last_vertex
//
// Each primitive yields one vertex per cycle unless the output stalls: a plain vertex 1, a
// cross 4, a rectangle 5 and an oval SEGMENTS+1; the back end sequencer sets these counts.
// Accepted input goes via the queue, command registers and stage 1 to the output register.
// The front end keeps accepting into a 2-entry command queue while the back end expands,
// so input and output stall independently; out_tready low freezes the back end pipeline.
// rst_n (synchronous) clears the queue, the sequencer and all valid flags; no clearing pass.
`default_nettype none

module overlay_primitive_vertex_expander #(
  parameter int SEGMENTS    = 32,
  parameter int COORD_WIDTH = 18
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // coord_a, coord_b, coord_c, coord_d from the lowest bit up, zero padded
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // req_type
  input  wire logic [1:0]                             in_tuser,
  input  wire logic                                   in_tlast,
  input  wire logic                                   in_tvalid,
  output      logic                                   in_tready,
  // vertex_x, vertex_y from the lowest bit up, zero padded
  output      logic [((2*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  // overflow, batch_done from the lowest bit up
  output      logic [1:0]                             out_tuser,
  output      logic                                   out_tlast,
  output      logic                                   out_tvalid,
  input  wire logic                                   out_tready
);
  import ovx_pkg::*;

  localparam int CMDW   = 8 * COORD_WIDTH + 4;
  localparam int OUT_DW = ((2 * COORD_WIDTH + 7) / 8) * 8;

  ovx_ctl_t                 fr_ctl;
  logic [CMDW-1:0]          fr_data;
  ovx_ctl_t                 q_ctl;
  logic [CMDW-1:0]          q_data;
  logic                     q_valid;
  logic                     q_pop;
  logic [COORD_WIDTH-1:0]   vx, vy;
  logic                     v_ovf, v_last, v_bend;

  // classify and precompute cross endpoints
  ovx_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .cmd_ctl  (fr_ctl),
    .cmd_data (fr_data)
  );

  // decouples input acceptance from vertex generation
  ovx_queue #(
    .WIDTH (CMDW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_ctl   (fr_ctl),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_ctl    (q_ctl),
    .pop_data   (q_data)
  );

  // one vertex per cycle unless the output stalls, oval scaling, saturation, output register
  ovx_back #(
    .SEGMENTS    (SEGMENTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd_ctl   (q_ctl),
    .cmd_data  (q_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (vx),
    .out_y     (vy),
    .out_ovf   (v_ovf),
    .out_last  (v_last),
    .out_bend  (v_bend)
  );

  assign out_tdata = OUT_DW'({vy, vx});
  assign out_tuser = {v_bend, v_ovf};
  assign out_tlast = v_last;

endmodule

`default_nettype wire

FILE: rtl/core/ovx_front.sv
// Front end: unpacks an input transaction and precomputes cross endpoints.
`default_nettype none

module ovx_front #(
  parameter int COORD_WIDTH = 18
) (
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  wire logic [1:0]                         in_tuser,
  input  wire logic                               in_tlast,
  output      ovx_pkg::ovx_ctl_t                  cmd_ctl,
  output      logic [8*COORD_WIDTH+3:0]           cmd_data
);
  import ovx_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0] a;
  logic signed [CW-1:0] b;
  logic signed [CW-1:0] c;
  logic signed [CW-1:0] d;
  logic signed [CW+1:0] t_lox;
  logic signed [CW+1:0] t_hix;
  logic signed [CW+1:0] t_loy;
  logic signed [CW+1:0] t_hiy;

  assign a = in_tdata[CW-1:0];
  assign b = in_tdata[2*CW-1:CW];
  assign c = in_tdata[3*CW-1:2*CW];
  assign d = in_tdata[4*CW-1:3*CW];

  // floor((2*center -/+ size + 1) / 2): half size, round half up
  always_comb begin
    t_lox = {a[CW-1], a, 1'b0} - {{2{c[CW-1]}}, c} + (CW+2)'(1);
    t_hix = {a[CW-1], a, 1'b0} + {{2{c[CW-1]}}, c} + (CW+2)'(1);
    t_loy = {b[CW-1], b, 1'b0} - {{2{c[CW-1]}}, c} + (CW+2)'(1);
    t_hiy = {b[CW-1], b, 1'b0} + {{2{c[CW-1]}}, c} + (CW+2)'(1);
  end

  assign cmd_ctl.kind = in_tuser;
  assign cmd_ctl.bend = in_tlast;

  assign cmd_data = {t_hiy[CW+1:1], t_loy[CW+1:1], t_hix[CW+1:1], t_lox[CW+1:1],
                     d, c, b, a};

endmodule

`default_nettype wire

FILE: rtl/core/ovx_queue.sv
// Short command queue between the front end and the vertex sequencer.
`default_nettype none

module ovx_queue #(
  parameter int WIDTH = 148
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output      logic              push_ready,
  input  wire ovx_pkg::ovx_ctl_t push_ctl,
  input  wire logic [WIDTH-1:0]  push_data,
  output      logic              pop_valid,
  input  wire logic              pop,
  output      ovx_pkg::ovx_ctl_t pop_ctl,
  output      logic [WIDTH-1:0]  pop_data
);
  import ovx_pkg::*;

  localparam int PW = (OVX_QDEPTH > 1) ? $clog2(OVX_QDEPTH) : 1;
  localparam int CNTW = $clog2(OVX_QDEPTH + 1);

  ovx_ctl_t         ctl_r  [OVX_QDEPTH];
  logic [WIDTH-1:0] data_r [OVX_QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push;

  assign push_ready = (count_r != CNTW'(OVX_QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign pop_ctl    = ctl_r[rd_ptr_r];
  assign pop_data   = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(OVX_QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(OVX_QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_r[wr_ptr_r]  <= push_ctl;
      data_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(OVX_QDEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !pop) |=> (count_r == $past(count_r) + CNTW'(1)))
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ovx_back.sv
// Back end: walks each command's vertex list, scales oval points, saturates.
`default_nettype none

module ovx_back #(
  parameter int SEGMENTS    = 32,
  parameter int COORD_WIDTH = 18
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cmd_valid,
  output      logic                     cmd_pop,
  input  wire ovx_pkg::ovx_ctl_t        cmd_ctl,
  input  wire logic [8*COORD_WIDTH+3:0] cmd_data,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [COORD_WIDTH-1:0]   out_x,
  output      logic [COORD_WIDTH-1:0]   out_y,
  output      logic                     out_ovf,
  output      logic                     out_last,
  output      logic                     out_bend
);
  import ovx_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = COORD_WIDTH + 16;
  localparam int SW   = COORD_WIDTH + 2;
  localparam int IDXW = $clog2(SEGMENTS + 1);

  // per-segment cos/sin, Q14, fixed at elaboration
  logic signed [15:0] cos_tab [SEGMENTS+1];
  logic signed [15:0] sin_tab [SEGMENTS+1];

  for (genvar g = 0; g <= SEGMENTS; g++) begin : g_tab
    localparam logic [16:0] PHASE = 17'((g * 65536 + SEGMENTS / 2) / SEGMENTS);
    assign cos_tab[g] = ovx_trig(PHASE, 1'b0);
    assign sin_tab[g] = ovx_trig(PHASE, 1'b1);
  end

  // current command
  logic                 busy_r, busy_nxt;
  logic [IDXW-1:0]      idx_r, idx_nxt;
  logic [1:0]           kind_r;
  logic                 bend_r;
  logic signed [CW-1:0] a_r, b_r, c_r, d_r;
  logic signed [CW:0]   lox_r, hix_r, loy_r, hiy_r;

  // stage 1: selected base and oval products
  logic                 s1_valid_r;
  logic signed [CW:0]   s1_bx_r, s1_by_r;
  logic signed [PW-1:0] s1_px_r, s1_py_r;
  logic                 s1_use_r, s1_last_r, s1_bend_r;

  // stage 2: output register
  logic                 out_valid_r;
  logic [CW-1:0]        out_x_r, out_y_r;
  logic                 out_ovf_r, out_last_r, out_bend_r;

  logic                 en, step, at_last;
  logic [IDXW-1:0]      last_idx;
  logic signed [CW:0]   sel_bx, sel_by;
  logic                 sel_use;
  logic signed [PW-1:0] prod_x, prod_y;
  logic signed [PW-1:0] rnd_x, rnd_y;
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 ovf_x, ovf_y;
  logic [CW-1:0]        sat_x, sat_y;

  function automatic logic [IDXW-1:0] run_end(input logic [1:0] kind);
    case (kind)
      KIND_VERTEX: return IDXW'(0);
      KIND_CROSS:  return IDXW'(3);
      KIND_RECT:   return IDXW'(4);
      default:     return IDXW'(SEGMENTS);
    endcase
  endfunction

  assign en       = !out_valid_r || out_ready;
  assign step     = en && busy_r;
  assign last_idx = run_end(kind_r);
  assign at_last  = (idx_r == last_idx);
  assign cmd_pop  = cmd_valid && (!busy_r || (step && at_last));

  // index parks at zero after a run so the tables are never read past the end
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (cmd_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (step) begin
      busy_nxt = !at_last;
      idx_nxt  = at_last ? '0 : idx_r + IDXW'(1);
    end
  end

  // vertex selection for the current index
  always_comb begin
    sel_bx  = {a_r[CW-1], a_r};
    sel_by  = {b_r[CW-1], b_r};
    sel_use = 1'b0;
    case (kind_r)
      KIND_VERTEX: begin
      end
      KIND_CROSS: begin
        if (idx_r == IDXW'(0)) begin
          sel_bx = lox_r;
        end else if (idx_r == IDXW'(1)) begin
          sel_bx = hix_r;
        end else if (idx_r == IDXW'(2)) begin
          sel_by = loy_r;
        end else begin
          sel_by = hiy_r;
        end
      end
      KIND_RECT: begin
        if (idx_r == IDXW'(1)) begin
          sel_bx = {c_r[CW-1], c_r};
        end else if (idx_r == IDXW'(2)) begin
          sel_bx = {c_r[CW-1], c_r};
          sel_by = {d_r[CW-1], d_r};
        end else if (idx_r == IDXW'(3)) begin
          sel_by = {d_r[CW-1], d_r};
        end
      end
      default: begin
        sel_use = 1'b1;
      end
    endcase
  end

  assign prod_x = PW'(cos_tab[idx_r]) * PW'(c_r);
  assign prod_y = PW'(sin_tab[idx_r]) * PW'(d_r);

  // stage 2: round half up, add center, saturate
  assign rnd_x = (s1_px_r + PW'(16384)) >>> 15;
  assign rnd_y = (s1_py_r + PW'(16384)) >>> 15;
  assign sum_x = SW'(s1_bx_r) + (s1_use_r ? SW'(rnd_x) : SW'(0));
  assign sum_y = SW'(s1_by_r) + (s1_use_r ? SW'(rnd_y) : SW'(0));

  assign ovf_x = !((&sum_x[SW-1:CW-1]) || !(|sum_x[SW-1:CW-1]));
  assign ovf_y = !((&sum_y[SW-1:CW-1]) || !(|sum_y[SW-1:CW-1]));
  assign sat_x = ovf_x ? {sum_x[SW-1], {(CW-1){!sum_x[SW-1]}}} : sum_x[CW-1:0];
  assign sat_y = ovf_y ? {sum_y[SW-1], {(CW-1){!sum_y[SW-1]}}} : sum_y[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (en) begin
        s1_valid_r  <= busy_r;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      kind_r <= cmd_ctl.kind;
      bend_r <= cmd_ctl.bend;
      a_r    <= cmd_data[CW-1:0];
      b_r    <= cmd_data[2*CW-1:CW];
      c_r    <= cmd_data[3*CW-1:2*CW];
      d_r    <= cmd_data[4*CW-1:3*CW];
      lox_r  <= cmd_data[5*CW:4*CW];
      hix_r  <= cmd_data[6*CW+1:5*CW+1];
      loy_r  <= cmd_data[7*CW+2:6*CW+2];
      hiy_r  <= cmd_data[8*CW+3:7*CW+3];
    end
    if (en) begin
      s1_bx_r    <= sel_bx;
      s1_by_r    <= sel_by;
      s1_px_r    <= prod_x;
      s1_py_r    <= prod_y;
      s1_use_r   <= sel_use;
      s1_last_r  <= at_last;
      s1_bend_r  <= at_last && bend_r;
      out_x_r    <= sat_x;
      out_y_r    <= sat_y;
      out_ovf_r  <= ovf_x || ovf_y;
      out_last_r <= s1_last_r;
      out_bend_r <= s1_bend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;
  assign out_bend  = out_bend_r;

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= last_idx))
    else $error("vertex index ran past end of run");
  a_bend_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bend_r) |-> out_last_r)
    else $error("batch done without last vertex");
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (busy_r && (idx_r == '0)))
    else $error("new command did not start at index zero");
  a_no_ovf_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s1_valid_r && !s1_use_r && (s1_bx_r[CW] == s1_bx_r[CW-1])
     && (s1_by_r[CW] == s1_by_r[CW-1])) |=> !out_ovf_r)
    else $error("in-range vertex flagged as saturated");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the overlay primitive vertex expander.
`timescale 1ns / 1ps

module tb_top;
  import ovx_pkg::*;

  localparam int SEGMENTS    = 32;
  localparam int COORD_WIDTH = 18;
  localparam int IN_W        = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * COORD_WIDTH + 7) / 8) * 8;

  // watchdog: cycles with no transaction on either side before giving up
  localparam int STALL_LIMIT = 5000;
  // settle time after the last vertex
  localparam int TAIL_CYCLES = 16;

  localparam longint COORD_HI = 131071;
  localparam longint COORD_LO = -131072;

  localparam logic signed [17:0] CMAX = 18'sh1FFFF;
  localparam logic signed [17:0] CMIN = 18'sh20000;
  localparam logic signed [17:0] ONE  = 18'sd16384;

  // quarter-sine Taylor coefficients, unsigned Q30
  localparam logic [63:0] SIN_K1 = 64'd1686629713;
  localparam logic [63:0] SIN_K3 = 64'd693598668;
  localparam logic [63:0] SIN_K5 = 64'd85569306;
  localparam logic [63:0] SIN_K7 = 64'd5026990;
  localparam logic [63:0] SIN_K9 = 64'd172272;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               ovf;
    logic               last;
    logic               bdone;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_W-1:0]  in_tdata = '0;
  logic [1:0]       in_tuser = KIND_VERTEX;
  logic             in_tlast = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  // vertices predicted for accepted primitives, oldest first
  vertex_t pending_vertices[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  overlay_primitive_vertex_expander #(
    .SEGMENTS(SEGMENTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Vertex prediction
  // ---------------------------------------------------------------------------

  // floor((v + 2^(n-1)) / 2^n): round half up
  function automatic longint round_half_up(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // sin(pi/2 * r/16384) in Q14; Horner in unsigned Q30, truncating products
  function automatic longint quarter_wave(input int unsigned r);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] acc;
    z   = 64'(r) << 16;
    z2  = (z * z) >> 30;
    acc = SIN_K9;
    acc = SIN_K7 - ((z2 * acc) >> 30);
    acc = SIN_K5 - ((z2 * acc) >> 30);
    acc = SIN_K3 - ((z2 * acc) >> 30);
    acc = SIN_K1 - ((z2 * acc) >> 30);
    return longint'((((z * acc) >> 30) + 64'd32768) >> 16);
  endfunction

  // saturate both coordinates and queue the vertex
  function automatic void push_vertex(input longint x, input longint y,
                                      input logic last, input logic bend);
    vertex_t v;
    v.ovf = 1'b0;
    if (x > COORD_HI) begin
      x = COORD_HI;
      v.ovf = 1'b1;
    end else if (x < COORD_LO) begin
      x = COORD_LO;
      v.ovf = 1'b1;
    end
    if (y > COORD_HI) begin
      y = COORD_HI;
      v.ovf = 1'b1;
    end else if (y < COORD_LO) begin
      y = COORD_LO;
      v.ovf = 1'b1;
    end
    v.x     = x[17:0];
    v.y     = y[17:0];
    v.last  = last;
    v.bdone = last & bend;
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  function automatic void expand_primitive(input logic [1:0] kind,
                                           input logic signed [17:0] ca,
                                           input logic signed [17:0] cb,
                                           input logic signed [17:0] cc,
                                           input logic signed [17:0] cd,
                                           input logic bend);
    longint a;
    longint b;
    longint c;
    longint d;
    longint s_val;
    longint c_val;
    longint sr;
    longint cr;
    logic [63:0] phase;
    int unsigned r;
    int k;
    a = ca;
    b = cb;
    c = cc;
    d = cd;
    case (kind)
      KIND_VERTEX: begin
        push_vertex(a, b, 1'b1, bend);
      end
      KIND_CROSS: begin
        // half size is kept exact; each end is rounded once
        push_vertex(round_half_up(2 * a - c, 1), b, 1'b0, bend);
        push_vertex(round_half_up(2 * a + c, 1), b, 1'b0, bend);
        push_vertex(a, round_half_up(2 * b - c, 1), 1'b0, bend);
        push_vertex(a, round_half_up(2 * b + c, 1), 1'b1, bend);
      end
      KIND_RECT: begin
        push_vertex(a, b, 1'b0, bend);
        push_vertex(c, b, 1'b0, bend);
        push_vertex(c, d, 1'b0, bend);
        push_vertex(a, d, 1'b0, bend);
        push_vertex(a, b, 1'b1, bend);
      end
      default: begin
        for (k = 0; k <= SEGMENTS; k++) begin
          phase = (64'(k) * 64'd65536 + 64'(SEGMENTS / 2)) / 64'(SEGMENTS);
          r  = int'(phase[13:0]);
          sr = quarter_wave(r);
          cr = quarter_wave(16384 - r);
          case (phase[15:14])
            2'd0: begin
              c_val = cr;
              s_val = sr;
            end
            2'd1: begin
              c_val = -sr;
              s_val = cr;
            end
            2'd2: begin
              c_val = -cr;
              s_val = -sr;
            end
            default: begin
              c_val = sr;
              s_val = -cr;
            end
          endcase
          push_vertex(a + round_half_up(c_val * c, 15), b + round_half_up(s_val * d, 15),
                      k == SEGMENTS, bend);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, scoreboard, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] vertex mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : check_vertices
    vertex_t want;
    vertex_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x     = out_tdata[17:0];
      got.y     = out_tdata[35:18];
      got.ovf   = out_tuser[0];
      got.bdone = out_tuser[1];
      got.last  = out_tlast;
      if (pending_vertices.size() == 0) begin
        note_mismatch($sformatf("unexpected vertex x=%0d y=%0d", got.x, got.y));
      end else begin
        want = pending_vertices.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.ovf !== want.ovf ||
            got.last !== want.last || got.bdone !== want.bdone) begin
          note_mismatch($sformatf(
            "exp x=%0d y=%0d ovf=%b last=%b done=%b, got x=%0d y=%0d ovf=%b last=%b done=%b",
            want.x, want.y, want.ovf, want.last, want.bdone,
            got.x, got.y, got.ovf, got.last, got.bdone));
        end
      end
    end
  end

  // any transaction on either side resets the stall counter
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Presents one primitive, holds it until accepted, then predicts its vertices.
  // Returns on the accepting edge with tvalid still high.
  task automatic send_primitive(input logic [1:0] kind, input logic signed [17:0] a,
                                input logic signed [17:0] b, input logic signed [17:0] c,
                                input logic signed [17:0] d, input logic bend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, c, b, a};
    in_tuser  <= kind;
    in_tlast  <= bend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expand_primitive(kind, a, b, c, d, bend);
  endtask

  // Mostly moderate coordinates so ovals and crosses stay in range,
  // with full-range values and the edges mixed in.
  function automatic logic signed [17:0] random_coord();
    logic signed [17:0] v;
    case ($urandom_range(3))
      0: v = 18'($urandom);
      1, 2: v = 18'($signed($urandom_range(65535)) - 32768);
      default: begin
        case ($urandom_range(4))
          0: v = CMAX;
          1: v = CMIN;
          2: v = 18'sd0;
          3: v = -18'sd1;
          default: v = 18'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random_primitive();
    send_primitive(2'($urandom_range(3)), random_coord(), random_coord(), random_coord(),
                   random_coord(), 1'($urandom_range(1)));
  endtask

  // drop tvalid and wait until every predicted vertex has been seen
  task automatic wait_for_vertices();
    in_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_primitive(KIND_VERTEX, CMAX, CMIN, 18'sd0, 18'sd0, 1'b1);
    send_primitive(KIND_VERTEX, CMIN, CMAX, CMAX, CMIN, 1'b0);
    send_primitive(KIND_VERTEX, 18'sd0, -18'sd1, -18'sd1, -18'sd1, 1'b1);
    // odd sizes land exactly on the rounding tie
    send_primitive(KIND_CROSS, 18'sd0, 18'sd0, 18'sd1, 18'sd0, 1'b0);
    send_primitive(KIND_CROSS, 18'sd0, 18'sd0, -18'sd1, 18'sd0, 1'b1);
    // saturation at both ends
    send_primitive(KIND_CROSS, CMAX, CMAX, CMAX, 18'sd0, 1'b0);
    send_primitive(KIND_CROSS, CMIN, CMIN, CMAX, CMAX, 1'b1);
    send_primitive(KIND_CROSS, 18'sd0, 18'sd0, CMIN, 18'sd0, 1'b0);
    send_primitive(KIND_CROSS, ONE, -ONE, ONE, 18'sd0, 1'b1);
    send_primitive(KIND_RECT, CMIN, CMIN, CMAX, CMAX, 1'b1);
    send_primitive(KIND_RECT, CMAX, 18'sd0, CMIN, ONE, 1'b0);
    send_primitive(KIND_OVAL, 18'sd0, 18'sd0, ONE, ONE, 1'b1);
    // negative extents mirror the oval
    send_primitive(KIND_OVAL, ONE, -ONE, -ONE, 18'sd32768, 1'b0);
    send_primitive(KIND_OVAL, CMAX, CMIN, CMAX, CMAX, 1'b1);
    send_primitive(KIND_OVAL, 18'sd0, 18'sd0, CMIN, CMIN, 1'b0);
    send_primitive(KIND_OVAL, 18'sd3, -18'sd5, 18'sd0, 18'sd0, 1'b1);
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_primitive();
  endtask

  // sender holds off until the block has fully drained between primitives
  task automatic test_drained_handoff();
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    repeat (6) begin
      send_random_primitive();
      wait_for_vertices();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_stream(0, 0, 32);
    test_random_stream(72, 0, 32);
    test_random_stream(0, 72, 32);
    test_random_stream(36, 36, 32);
    test_drained_handoff();

    wait_for_vertices();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_vertices.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pending_vertices.size() != 0)
        $display("%0d vertices never arrived", pending_vertices.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ovx_pkg.sv
rtl/core/ovx_front.sv
rtl/core/ovx_queue.sv
rtl/core/ovx_back.sv
rtl/core/overlay_primitive_vertex_expander.sv
test/tb_top.sv
